>>> rtl/fpdb_pkg.sv
// Shared widths, constants and controller/datapath interface types for the
// frame power in dB unit. No dependencies.
package fpdb_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SQ_W          = 31;
    localparam int SUM_W         = 46;
    localparam int COUNT_W       = 17;
    localparam int EXP_W         = 6;
    localparam int FRAC_W        = 16;
    localparam int LOG_W         = EXP_W + FRAC_W;
    localparam int DIFF_W        = LOG_W + 2;
    localparam int MANT_W        = 31;
    localparam int DBK_W         = 18;
    localparam int PROD_W        = LOG_W + DBK_W;
    localparam int DB_W          = 16;
    localparam int Q_W           = PROD_W - 23;
    localparam int NORM_STEPS    = 6;
    localparam int SQ_STEPS      = FRAC_W;
    localparam int STEP_W        = 4;
    localparam int MAX_FRAME_DEF = 65536;

    localparam logic [DBK_W-1:0]  DB_PER_LOG2 = 18'd197283;
    localparam logic [DIFF_W-1:0] LOG_BIAS    = 24'd1966080;
    localparam logic [PROD_W:0]   ROUND_HALF  = 41'd8388608;
    localparam logic [Q_W-1:0]    Q_LIMIT     = 17'd32768;
    localparam logic [DB_W-1:0]   DB_MIN      = 16'h8000;

    typedef struct packed {
        logic       load_sum;
        logic       load_count;
        logic       save_a;
        logic       norm_step;
        logic [2:0] norm_idx;
        logic       sq_step;
        logic       diff;
        logic       mult;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> rtl/frame_power_db_unit.sv
// Frame power in dB: top level joining the accumulator, the sequencer and
// the log datapath. Depends on fpdb_pkg, fpdb_accum, fpdb_ctrl and fpdb_dp.
//
// Samples are taken one per cycle, while ready is high, into a saturating
// sum of squares. When a frame closes (last sample flag, or MAX_FRAME
// samples), its sum and count move to a snapshot register and the next frame
// starts accumulating. A shared log2 unit then works on the snapshot: it
// takes it, runs six normalize steps and sixteen squaring steps for the sum,
// loads the count, runs the same steps for the count, then forms the
// difference, does the dB scaling multiply and loads the output register
// once that register is free. Ready stays low from a closing transfer until
// the log unit takes the snapshot, which is later while the previous frame is
// still in the log unit or its result waits. The result is signed Q8.8; zero
// power gives -32768.
module frame_power_db_unit #(
    parameter int MAX_FRAME = fpdb_pkg::MAX_FRAME_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [fpdb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [fpdb_pkg::DB_W-1:0]     o_power_db
);
    import fpdb_pkg::*;

    logic               w_pend;
    logic [SUM_W-1:0]   w_snap_sum;
    logic [COUNT_W-1:0] w_snap_count;
    t_cmd               w_cmd;
    t_status            w_status;
    logic [DB_W-1:0]    w_power_db;

    fpdb_accum #(
        .MAX_FRAME(MAX_FRAME)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .i_take       (w_cmd.load_sum),
        .o_pend       (w_pend),
        .o_snap_sum   (w_snap_sum),
        .o_snap_count (w_snap_count)
    );

    fpdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pend  (w_pend),
        .i_status(w_status),
        .o_cmd   (w_cmd)
    );

    fpdb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_snap_sum  (w_snap_sum),
        .i_snap_count(w_snap_count),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_power_db  (w_power_db)
    );

    assign o_power_db = $signed(w_power_db);

    a_close_sets_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_sample) |=> w_pend)
        else $error("A closed frame did not produce a pending snapshot.");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_db[DB_W-1] || (o_power_db == '0)))
        else $error("Frame power result is above 0 dB.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_valid || i_ready))
        else $error("A result was overwritten before its transfer.");

    a_take_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_sum |-> w_pend)
        else $error("The log unit took a snapshot that was not pending.");

endmodule

>>> rtl/fpdb_accum.sv
// Sample accumulator: running sum of squares, sample count and the frame
// snapshot handed to the log datapath. Depends on fpdb_pkg.
module fpdb_accum #(
    parameter int MAX_FRAME = fpdb_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [fpdb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_sample,
    input  logic                                i_take,
    output logic                                o_pend,
    output logic [fpdb_pkg::SUM_W-1:0]          o_snap_sum,
    output logic [fpdb_pkg::COUNT_W-1:0]        o_snap_count
);
    import fpdb_pkg::*;

    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic                r_pend;
    logic [SUM_W-1:0]    r_snap_sum;
    logic [COUNT_W-1:0]  r_snap_count;
    logic signed [2*SAMPLE_W-1:0] w_prod;
    logic [SUM_W:0]      w_add;
    logic [SUM_W-1:0]    n_sum;
    logic [COUNT_W-1:0]  n_count;
    logic                w_close;
    logic                w_accept;

    always_comb begin
        w_prod   = i_sample * i_sample;
        w_add    = {1'b0, r_sum} + (SUM_W + 1)'(w_prod[SQ_W-1:0]);
        n_sum    = w_add[SUM_W] ? {SUM_W{1'b1}} : w_add[SUM_W-1:0];
        n_count  = r_count + COUNT_W'(1);
        w_close  = i_last_sample || (n_count == COUNT_W'(MAX_FRAME));
        w_accept = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_take) begin
                r_pend <= 1'b0;
            end
            if (w_accept) begin
                if (w_close) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_pend  <= 1'b1;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_close) begin
            r_snap_sum   <= n_sum;
            r_snap_count <= n_count;
        end
    end

    assign o_ready      = !r_pend;
    assign o_pend       = r_pend;
    assign o_snap_sum   = r_snap_sum;
    assign o_snap_count = r_snap_count;

endmodule

>>> rtl/fpdb_ctrl.sv
// Sequencer for the end-of-frame computation: two logarithms on a shared
// unit, difference, scaling and result hand-off. Depends on fpdb_pkg.
module fpdb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pend,
    input  fpdb_pkg::t_status i_status,
    output fpdb_pkg::t_cmd    o_cmd
);
    import fpdb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_NORM = 4'd1;
    localparam logic [3:0] S_A_SQ   = 4'd2;
    localparam logic [3:0] S_LOAD_B = 4'd3;
    localparam logic [3:0] S_B_NORM = 4'd4;
    localparam logic [3:0] S_B_SQ   = 4'd5;
    localparam logic [3:0] S_DIFF   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.norm_idx = r_step[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_pend) begin
                    o_cmd.load_sum = 1'b1;
                    n_state = S_A_NORM;
                    n_step  = '0;
                end
            end
            S_A_NORM, S_B_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (r_step == STEP_W'(NORM_STEPS - 1)) begin
                    n_state = (r_state == S_A_NORM) ? S_A_SQ : S_B_SQ;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_A_SQ, S_B_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (r_step == STEP_W'(SQ_STEPS - 1)) begin
                    n_state = (r_state == S_A_SQ) ? S_LOAD_B : S_DIFF;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_LOAD_B: begin
                o_cmd.load_count = 1'b1;
                o_cmd.save_a     = 1'b1;
                n_state = S_B_NORM;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

>>> rtl/fpdb_dp.sv
// Datapath for the end-of-frame computation: stepwise normalizer, squaring
// log2 unit, difference, dB scaling and output register. Depends on fpdb_pkg.
module fpdb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpdb_pkg::t_cmd               i_cmd,
    output fpdb_pkg::t_status            o_status,
    input  logic [fpdb_pkg::SUM_W-1:0]   i_snap_sum,
    input  logic [fpdb_pkg::COUNT_W-1:0] i_snap_count,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fpdb_pkg::DB_W-1:0]    o_power_db
);
    import fpdb_pkg::*;

    logic [SUM_W-1:0]    r_norm;
    logic [EXP_W-1:0]    r_shift;
    logic [MANT_W-1:0]   r_m;
    logic [FRAC_W-1:0]   r_frac;
    logic [COUNT_W-1:0]  r_cnt;
    logic                r_zero;
    logic [LOG_W-1:0]    r_log_a;
    logic [LOG_W-1:0]    r_mag;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    logic [DB_W-1:0]     r_power_db;

    logic                w_z;
    logic [EXP_W-1:0]    w_amt;
    logic [SUM_W-1:0]    n_norm;
    logic [EXP_W-1:0]    n_shift;
    logic [EXP_W-1:0]    w_exp;
    logic [2*MANT_W-1:0] w_sq;
    logic [MANT_W:0]     w_sqv;
    logic [MANT_W-1:0]   n_m;
    logic signed [DIFF_W-1:0] w_lv;
    logic [LOG_W-1:0]    n_mag;
    logic [PROD_W:0]     w_rnd;
    logic [Q_W-1:0]      w_q;
    logic [DB_W-1:0]     n_power_db;

    always_comb begin
        unique case (i_cmd.norm_idx)
            3'd0: begin w_z = (r_norm[SUM_W-1 -: 32] == '0); w_amt = 6'd32; end
            3'd1: begin w_z = (r_norm[SUM_W-1 -: 16] == '0); w_amt = 6'd16; end
            3'd2: begin w_z = (r_norm[SUM_W-1 -: 8] == '0);  w_amt = 6'd8;  end
            3'd3: begin w_z = (r_norm[SUM_W-1 -: 4] == '0);  w_amt = 6'd4;  end
            3'd4: begin w_z = (r_norm[SUM_W-1 -: 2] == '0);  w_amt = 6'd2;  end
            3'd5: begin w_z = !r_norm[SUM_W-1];               w_amt = 6'd1;  end
            default: begin w_z = 1'b0; w_amt = '0; end
        endcase
        n_norm  = w_z ? (r_norm << w_amt) : r_norm;
        n_shift = w_z ? (r_shift + w_amt) : r_shift;
        w_exp   = EXP_W'(SUM_W - 1) - r_shift;

        w_sq  = r_m * r_m;
        w_sqv = w_sq[2*MANT_W-1:MANT_W-1];
        n_m   = w_sqv[MANT_W] ? w_sqv[MANT_W:1] : w_sqv[MANT_W-1:0];

        w_lv  = $signed({2'b00, r_log_a}) - $signed({2'b00, w_exp, r_frac})
              - $signed(LOG_BIAS);
        n_mag = (w_lv > 0) ? '0 : LOG_W'(-w_lv);

        w_rnd = {1'b0, r_prod} + ROUND_HALF;
        w_q   = w_rnd[PROD_W:24];
        if (r_zero || (w_q >= Q_LIMIT)) begin
            n_power_db = DB_MIN;
        end else begin
            n_power_db = DB_W'(0) - w_q[DB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sum) begin
            r_norm  <= i_snap_sum;
            r_cnt   <= i_snap_count;
            r_zero  <= (i_snap_sum == '0);
            r_shift <= '0;
            r_frac  <= '0;
        end
        if (i_cmd.load_count) begin
            r_norm  <= SUM_W'(r_cnt);
            r_shift <= '0;
            r_frac  <= '0;
        end
        if (i_cmd.save_a) begin
            r_log_a <= {w_exp, r_frac};
        end
        if (i_cmd.norm_step) begin
            r_norm  <= n_norm;
            r_shift <= n_shift;
            r_m     <= n_norm[SUM_W-1 -: MANT_W];
        end
        if (i_cmd.sq_step) begin
            r_m    <= n_m;
            r_frac <= {r_frac[FRAC_W-2:0], w_sqv[MANT_W]};
        end
        if (i_cmd.diff) begin
            r_mag <= n_mag;
        end
        if (i_cmd.mult) begin
            r_prod <= r_mag * DB_PER_LOG2;
        end
        if (i_cmd.finish) begin
            r_power_db <= n_power_db;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_power_db        = r_power_db;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for frame_power_db_unit: frames of Q1.15 samples in, Q8.8 dB power out.
// Depends on fpdb_pkg and frame_power_db_unit; the expected dB values come from an in-bench
// fixed-point model of the sum of squares, the log2 and the dB scaling.
module tb_top;
    import fpdb_pkg::*;

    localparam int              FRAME_LIMIT     = MAX_FRAME_DEF;
    localparam int              RANDOM_ITEMS    = 1770;
    localparam int              CYCLE_LIMIT     = 1000000;
    localparam int              HOLD_OFF_CYCLES = 400;
    localparam int              HOLD_AT_RESULT  = 30;
    localparam int              TAIL_CYCLES     = 100;
    localparam int              IDLE_PCT        = 13;
    localparam longint unsigned SUM_CEIL        = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned DB_SCALE_Q16    = 64'd197283;
    localparam longint unsigned ROUND_Q24       = 64'd1 << 23;
    localparam longint unsigned MAG_CEIL        = 64'd32768;

    typedef enum int {
        STYLE_FULL,
        STYLE_SMALL,
        STYLE_EXTREME,
        STYLE_SILENT
    } t_frame_style;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
        bit                         wait_drain;
        bit                         steady;
    } t_sample_item;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_last_sample;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [DB_W-1:0]     o_power_db;

    t_sample_item           pending[$];
    t_sample_item           next_item;
    logic signed [DB_W-1:0] db_expect[$];
    logic signed [DB_W-1:0] want_db;
    longint unsigned        acc_sum;
    longint unsigned        acc_count;
    int                     frames_closed;
    int                     samples_taken;
    int                     results_checked;
    int                     mismatches;
    int                     cycles;
    int                     hold_left;
    bit                     hold_done;
    bit                     sample_fire;

    frame_power_db_unit #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_power_db   (o_power_db)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint log2_fix(input longint unsigned v);
        int              e;
        int              i;
        longint unsigned m;
        longint          frac;
        e = 63;
        while (e > 0 && v[e] == 1'b0) e--;
        if (e > 30) begin
            m = v >> (e - 30);
        end else begin
            m = v << (30 - e);
        end
        frac = 0;
        for (i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                frac = frac | (64'sd1 << i);
                m = m >> 1;
            end
        end
        return longint'(e) * 65536 + frac;
    endfunction

    function automatic logic signed [DB_W-1:0] predict_db(input longint unsigned sum,
                                                          input longint unsigned cnt);
        longint          lv;
        longint unsigned mag;
        longint unsigned q;
        if (sum == 0 || cnt == 0) begin
            return DB_MIN;
        end
        lv = log2_fix(sum) - log2_fix(cnt) - longint'(30) * 65536;
        if (lv > 0) begin
            lv = 0;
        end
        mag = -lv;
        q = (mag * DB_SCALE_Q16 + ROUND_Q24) >> 24;
        if (q > MAG_CEIL) begin
            q = MAG_CEIL;
        end
        return DB_W'(64'd0 - q);
    endfunction

    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        longint          mag;
        longint unsigned sq;
        mag = smp;
        if (mag < 0) begin
            mag = -mag;
        end
        sq = mag * mag;
        if (acc_sum > SUM_CEIL - sq) begin
            acc_sum = SUM_CEIL;
        end else begin
            acc_sum = acc_sum + sq;
        end
        if (acc_count < FRAME_LIMIT) begin
            acc_count++;
        end
        if (lst || acc_count >= FRAME_LIMIT) begin
            db_expect.push_back(predict_db(acc_sum, acc_count));
            acc_sum = 0;
            acc_count = 0;
            frames_closed++;
        end
    endtask

    function automatic void add_item(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                                     input bit wait_drain, input bit steady);
        t_sample_item it;
        it.smp = smp;
        it.lst = lst;
        it.wait_drain = wait_drain;
        it.steady = steady;
        pending.push_back(it);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input t_frame_style style);
        case (style)
            STYLE_FULL: begin
                return SAMPLE_W'($urandom);
            end
            STYLE_SMALL: begin
                return SAMPLE_W'(int'($urandom_range(511)) - 256);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            default: begin
                return 16'sh0000;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, db_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_fire <= 1'b0;
        end else begin
            sample_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (db_expect.size() == 0) begin
                    mismatches++;
                    $display("%0t: power_db expected none, actual %0d", $time, o_power_db);
                end else begin
                    want_db = db_expect.pop_front();
                    results_checked++;
                    if (o_power_db !== want_db) begin
                        mismatches++;
                        $display("%0t: power_db expected %0d, actual %0d",
                                 $time, want_db, o_power_db);
                    end
                end
            end
            if (i_valid && o_ready) begin
                samples_taken++;
                absorb_sample(i_sample, i_last_sample);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !sample_fire) begin
                i_valid <= 1'b1;
            end else if (pending.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pending[0].wait_drain && db_expect.size() != 0) begin
                i_valid <= 1'b0;
            end else if (!pending[0].steady && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
            end else begin
                next_item = pending.pop_front();
                i_valid <= 1'b1;
                i_sample <= next_item.smp;
                i_last_sample <= next_item.lst;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && results_checked == HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                i_ready <= 1'b0;
            end else if (results_checked >= 45 && results_checked < 60) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int           n;
        int           k;
        int           len;
        int           frame_idx;
        int           r;
        t_frame_style style;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_last_sample = 1'b0;
        i_ready = 1'b0;
        acc_sum = 0;
        acc_count = 0;
        frames_closed = 0;
        samples_taken = 0;
        results_checked = 0;
        mismatches = 0;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        sample_fire = 1'b0;

        add_item(16'sh0000, 1'b1, 1'b0, 1'b0);
        add_item(16'sh8000, 1'b1, 1'b0, 1'b0);
        add_item(16'sh7FFF, 1'b1, 1'b0, 1'b0);
        add_item(16'sh0001, 1'b1, 1'b0, 1'b0);
        add_item(16'shFFFF, 1'b1, 1'b0, 1'b0);
        add_item(16'sh7FFF, 1'b0, 1'b0, 1'b0);
        add_item(16'sh8000, 1'b1, 1'b0, 1'b0);
        add_item(16'sh0000, 1'b0, 1'b0, 1'b0);
        add_item(16'sh0000, 1'b0, 1'b0, 1'b0);
        add_item(16'sh0000, 1'b1, 1'b0, 1'b0);
        add_item(16'sh3039, 1'b0, 1'b0, 1'b0);
        add_item(16'shCFC7, 1'b0, 1'b0, 1'b0);
        add_item(16'sh0100, 1'b1, 1'b0, 1'b0);
        // A lone LSB in a frame of zeros gives a very low dB value.
        add_item(16'sh0001, 1'b0, 1'b0, 1'b0);
        for (k = 0; k < 62; k++) begin
            add_item(16'sh0000, 1'b0, 1'b0, 1'b0);
        end
        add_item(16'sh0000, 1'b1, 1'b0, 1'b0);

        n = 0;
        frame_idx = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 60) begin
                len = $urandom_range(8, 1);
            end else if (r < 90) begin
                len = $urandom_range(64, 9);
            end else begin
                len = $urandom_range(400, 65);
            end
            r = $urandom_range(99);
            if (r < 5) begin
                style = STYLE_SILENT;
            end else if (r < 20) begin
                style = STYLE_EXTREME;
            end else if (r < 50) begin
                style = STYLE_SMALL;
            end else begin
                style = STYLE_FULL;
            end
            for (k = 0; k < len; k++) begin
                add_item(pick_sample(style), k == len - 1,
                         k == 0 && (frame_idx == 0 || frame_idx == 40),
                         n >= 600 && n < 1000);
                n++;
            end
            frame_idx++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid || db_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples in %0d frames: single-sample, silent and near-silent",
                 samples_taken, frames_closed);
        $display("frames, then random frames under stalls; %0d %s",
                 results_checked, "dB results checked.");
        if (mismatches == 0 && db_expect.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
